### hdl/msfa_pkg.sv
`default_nettype none
package msfa_pkg;

  localparam int LEVELS_DEF      = 3;
  localparam int LEVEL_SHIFT_DEF = 9;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int FRAME_BITS_DEF  = 40;

  localparam int CNT_W = 40;

  typedef enum logic [1:0] {
    OP_FREE    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_CARVE   = 2'd2,
    OP_RESERVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADLVL = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DISP   = 10'b0000000010,
    S_SRD    = 10'b0000000100,
    S_SLD    = 10'b0000001000,
    S_SPUSH  = 10'b0000010000,
    S_PRD    = 10'b0000100000,
    S_PLD    = 10'b0001000000,
    S_CARVE1 = 10'b0010000000,
    S_CARVE2 = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  // base frames spanned by one frame at level l
  function automatic logic [63:0] level_size(input int shift, input int l);
    return 64'(1) << (shift * l);
  endfunction

endpackage
`default_nettype wire

### hdl/msfa_ram.sv
`default_nettype none
module msfa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/multi_size_frame_allocator.sv
// Multi-size frame allocator: one LIFO free stack per page-size level.
// Input channel (in_valid / in_stall): one transaction carries opcode, level,
// frame_number and region_frames. Result channel (out_valid / out_stall): one
// transaction per input with frame_out, status, free_count and used_count.
// A single sequencer handles one transaction at a time; in_stall is high
// while it works. Free, reserve and a bad level or empty stack go from
// dispatch straight to the result load; an allocate pops its frame with a
// read state and a load state; a split pops a larger frame and pushes its
// 2^LEVEL_SHIFT pieces one level down, per level; a carve pushes aligned
// frames up the levels and then down again, and stops early if a stack fills.
// The stack RAM port takes one push or pop per cycle, and a pop waits for
// the registered read. The next input is taken in the cycle after the result
// load, so a new transaction is not taken before the last result is loaded.
// A result waits in the output register while out_stall is high; the
// sequencer holds in its output state until the register is taken.
// Synchronous reset (rst_n low) empties every stack and clears all counts;
// the stack RAM contents need no clearing.
`default_nettype none
module multi_size_frame_allocator #(
  parameter int LEVELS      = msfa_pkg::LEVELS_DEF,
  parameter int LEVEL_SHIFT = msfa_pkg::LEVEL_SHIFT_DEF,
  parameter int STACK_DEPTH = msfa_pkg::STACK_DEPTH_DEF,
  parameter int FRAME_BITS  = msfa_pkg::FRAME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [1:0]  in_level,
  input  wire logic [39:0] in_frame_number,
  input  wire logic [39:0] in_region_frames,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [39:0]      out_frame_out,
  output logic [1:0]       out_status,
  output logic [39:0]      out_free_count,
  output logic [39:0]      out_used_count
);

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW    = $clog2(STACK_DEPTH + 1);
  localparam int RD    = LEVELS * STACK_DEPTH;
  localparam int AW    = $clog2(RD);
  localparam int CW    = msfa_pkg::CNT_W;
  localparam int FB    = FRAME_BITS;
  localparam logic [TW-1:0] TOP_FULL = TW'(STACK_DEPTH);
  localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};

  msfa_pkg::state_t state_r;
  logic [1:0]    op_r;
  logic [1:0]    lvl_r;
  logic [LW-1:0] cur_r;
  logic [FB-1:0] start_r;
  logic [CW-1:0] rem_r;
  logic [LEVEL_SHIFT-1:0] cnt_r;
  logic [1:0]    status_r;
  logic [FB-1:0] frame_r;
  logic [TW-1:0] top_r  [LEVELS];
  logic [CW-1:0] used_r [LEVELS];

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [FB-1:0]  ram_rdata;

  logic           lvl_ok;
  logic [LW-1:0]  lvl_idx;
  logic [TW-1:0]  cur_top;
  logic           cur_full;
  logic [CW-1:0]  cur_size;
  logic [FB-1:0]  cur_step;
  logic [FB-1:0]  next_mask;
  logic           rem_fits;
  logic           found;
  logic [LW-1:0]  found_lvl;
  logic [CW:0]    reserve_sum;

  function automatic logic [AW-1:0] ram_addr(input logic [LW-1:0] l,
                                              input logic [TW-1:0] idx);
    return AW'(l) * AW'(STACK_DEPTH) + AW'(idx);
  endfunction

  assign lvl_ok    = {1'b0, lvl_r} < 3'(LEVELS);
  assign lvl_idx   = lvl_r[LW-1:0];
  assign cur_top   = top_r[cur_r];
  assign cur_full  = (cur_top == TOP_FULL);
  assign cur_size  = CW'(msfa_pkg::level_size(LEVEL_SHIFT, int'(cur_r)));
  assign cur_step  = FB'(msfa_pkg::level_size(LEVEL_SHIFT, int'(cur_r)));
  assign next_mask = FB'(msfa_pkg::level_size(LEVEL_SHIFT, int'(cur_r) + 1) - 64'd1);
  assign rem_fits  = (rem_r >= cur_size);
  assign reserve_sum = {1'b0, used_r[0]} + {1'b0, rem_r};
  assign in_stall  = (state_r != msfa_pkg::S_IDLE);

  // lowest non-empty level at or above the request
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if ((k >= int'(lvl_r)) && (top_r[k] != '0)) begin
        found     = 1'b1;
        found_lvl = LW'(k);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_addr(cur_r, cur_top);
    ram_raddr = ram_addr(cur_r, cur_top - TW'(1));
    case (state_r)
      msfa_pkg::S_DISP: begin
        ram_waddr = ram_addr(lvl_idx, top_r[lvl_idx]);
        ram_we    = (op_r == msfa_pkg::OP_FREE) && lvl_ok && (top_r[lvl_idx] != TOP_FULL);
      end
      msfa_pkg::S_SPUSH:  ram_we = !cur_full;
      msfa_pkg::S_CARVE1: ram_we = (int'(cur_r) != LEVELS - 1) &&
                                   ((start_r & next_mask) != '0) && rem_fits && !cur_full;
      msfa_pkg::S_CARVE2: ram_we = rem_fits && !cur_full;
      default:            ram_we = 1'b0;
    endcase
  end

  msfa_ram #(
    .WIDTH(FB),
    .DEPTH(RD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (start_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= msfa_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < LEVELS; k++) begin
        top_r[k]  <= '0;
        used_r[k] <= '0;
      end
    end else begin
      // drop the taken result unless the output state reloads it
      if (out_valid && !out_stall && (state_r != msfa_pkg::S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        msfa_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_opcode;
            lvl_r    <= in_level;
            start_r  <= FB'(in_frame_number);
            rem_r    <= in_region_frames;
            status_r <= msfa_pkg::ST_OK;
            frame_r  <= '0;
            state_r  <= msfa_pkg::S_DISP;
          end
        end
        msfa_pkg::S_DISP: begin
          case (op_r)
            msfa_pkg::OP_FREE: begin
              state_r <= msfa_pkg::S_OUT;
              if (!lvl_ok) begin
                status_r <= msfa_pkg::ST_BADLVL;
              end else if (top_r[lvl_idx] == TOP_FULL) begin
                status_r <= msfa_pkg::ST_FULL;
              end else begin
                top_r[lvl_idx] <= top_r[lvl_idx] + TW'(1);
                if (used_r[lvl_idx] != '0) begin
                  used_r[lvl_idx] <= used_r[lvl_idx] - CW'(1);
                end
              end
            end
            msfa_pkg::OP_ALLOC: begin
              if (!lvl_ok) begin
                status_r <= msfa_pkg::ST_BADLVL;
                state_r  <= msfa_pkg::S_OUT;
              end else if (!found) begin
                status_r <= msfa_pkg::ST_EMPTY;
                state_r  <= msfa_pkg::S_OUT;
              end else begin
                cur_r   <= found_lvl;
                state_r <= (found_lvl == lvl_idx) ? msfa_pkg::S_PRD : msfa_pkg::S_SRD;
              end
            end
            msfa_pkg::OP_CARVE: begin
              cur_r   <= '0;
              state_r <= msfa_pkg::S_CARVE1;
            end
            default: begin
              used_r[0] <= reserve_sum[CW] ? CNT_MAX : reserve_sum[CW-1:0];
              state_r   <= msfa_pkg::S_OUT;
            end
          endcase
        end
        msfa_pkg::S_SRD: begin
          top_r[cur_r] <= cur_top - TW'(1);
          state_r      <= msfa_pkg::S_SLD;
        end
        msfa_pkg::S_SLD: begin
          start_r <= ram_rdata;
          cur_r   <= cur_r - LW'(1);
          cnt_r   <= '0;
          state_r <= msfa_pkg::S_SPUSH;
        end
        msfa_pkg::S_SPUSH: begin
          if (!cur_full) begin
            top_r[cur_r] <= cur_top + TW'(1);
          end
          start_r <= start_r + cur_step;
          cnt_r   <= cnt_r + LEVEL_SHIFT'(1);
          if (cnt_r == {LEVEL_SHIFT{1'b1}}) begin
            state_r <= (cur_r == lvl_idx) ? msfa_pkg::S_PRD : msfa_pkg::S_SRD;
          end
        end
        msfa_pkg::S_PRD: begin
          top_r[cur_r] <= cur_top - TW'(1);
          state_r      <= msfa_pkg::S_PLD;
        end
        msfa_pkg::S_PLD: begin
          frame_r <= ram_rdata;
          if (used_r[cur_r] != CNT_MAX) begin
            used_r[cur_r] <= used_r[cur_r] + CW'(1);
          end
          state_r <= msfa_pkg::S_OUT;
        end
        msfa_pkg::S_CARVE1: begin
          if (int'(cur_r) == LEVELS - 1) begin
            state_r <= msfa_pkg::S_CARVE2;
          end else if (((start_r & next_mask) != '0) && rem_fits) begin
            if (cur_full) begin
              status_r <= msfa_pkg::ST_FULL;
              state_r  <= msfa_pkg::S_OUT;
            end else begin
              top_r[cur_r] <= cur_top + TW'(1);
              start_r      <= start_r + cur_step;
              rem_r        <= rem_r - cur_size;
            end
          end else begin
            cur_r <= cur_r + LW'(1);
          end
        end
        msfa_pkg::S_CARVE2: begin
          if (rem_fits) begin
            if (cur_full) begin
              status_r <= msfa_pkg::ST_FULL;
              state_r  <= msfa_pkg::S_OUT;
            end else begin
              top_r[cur_r] <= cur_top + TW'(1);
              start_r      <= start_r + cur_step;
              rem_r        <= rem_r - cur_size;
            end
          end else if (cur_r == '0) begin
            state_r <= msfa_pkg::S_OUT;
          end else begin
            cur_r <= cur_r - LW'(1);
          end
        end
        msfa_pkg::S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_frame_out  <= 40'(frame_r);
            out_status     <= status_r;
            out_free_count <= lvl_ok ? CW'(top_r[lvl_idx]) : '0;
            out_used_count <= lvl_ok ? used_r[lvl_idx] : '0;
            state_r        <= msfa_pkg::S_IDLE;
          end
        end
        default: state_r <= msfa_pkg::S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != msfa_pkg::S_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == msfa_pkg::S_OUT))
    else $error("result loaded outside output state");

  a_no_overflow_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != msfa_pkg::S_DISP) |-> !cur_full)
    else $error("push into a full stack");

  a_frame_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_out != '0) |-> (out_status == msfa_pkg::ST_OK))
    else $error("frame returned with error status");

endmodule
`default_nettype wire
